// ----- hdl/stereo_modulated_delay_core_defines.svh -----
// Assertion macros for the stereo modulated delay core.
// Bodies are empty when SYNTHESIS is defined; used by the top level only.
`ifndef STEREO_MODULATED_DELAY_CORE_DEFINES_SVH
`define STEREO_MODULATED_DELAY_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define SMD_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smd: same-cycle check failed");

`define SMD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smd: next-cycle check failed");

`else

`define SMD_ASSERT_IMPL(name, ante, cons)
`define SMD_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ----- hdl/smd_pkg.sv -----
// Shared types, constants and the quarter-wave sine table of the modulated delay.
// No dependencies.
package smd_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int SINE_TABLE_SIZE = 256;
    localparam int BUF_DEPTH_DEF   = 512;
    localparam int DEPTH_W         = 8;
    localparam int OFFSET_W        = DEPTH_W + 1;
    localparam int SINE_W          = 15;
    localparam int WET_W           = 16;
    localparam int PHASE_W         = 32;
    localparam int BDLY_W          = 9;
    localparam int Q15_SHIFT       = 15;
    localparam int APB_AW          = 4;
    localparam int APB_DW          = 32;

    localparam logic [WET_W-1:0] WET_ONE = WET_W'(1 << Q15_SHIFT);

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    typedef struct packed {
        t_sample left_sample;
        t_sample right_sample;
    } t_in_beat;

    typedef struct packed {
        t_sample left_out;
        t_sample right_out;
    } t_out_beat;

    typedef enum logic [1:0] {
        REG_WET_GAIN   = 2'd0,
        REG_PHASE_STEP = 2'd1,
        REG_BASE_DELAY = 2'd2,
        REG_MOD_DEPTH  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic advance;
        logic scale;
        logic divide;
    } t_lfo_ctl;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_hit;
        logic mul_en;
    } t_lane_ctl;

    typedef logic [SINE_W-1:0] t_sine_lut [SINE_TABLE_SIZE+1];

    function automatic t_sine_lut f_build_sine();
        t_sine_lut          lut;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] acc;
        for (int i = 0; i <= SINE_TABLE_SIZE; i++) begin
            x    = (PI_HALF_Q30 * 64'(i)) / 64'(SINE_TABLE_SIZE);
            term = x;
            acc  = $signed(x);
            for (int k = 1; k <= 6; k++) begin
                term = (term * x) >> 30;
                term = ((term * x) >> 30) / 64'((2 * k) * (2 * k + 1));
                if ((k % 2) == 1) begin
                    acc = acc - $signed(term);
                end else begin
                    acc = acc + $signed(term);
                end
            end
            if (acc < 0) begin
                acc = '0;
            end
            v = (64'(acc) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            lut[i] = v[SINE_W-1:0];
        end
        return lut;
    endfunction

    localparam t_sine_lut SINE_LUT = f_build_sine();

endpackage

// ----- hdl/smd_stream_if.sv -----
// Valid/ready stream channel carrying one payload beat of type T.
// No dependencies.
interface smd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/smd_lfo.sv -----
// Phase accumulator, quarter-wave sine lookup and depth scaling to a signed tap offset.
// Depends on smd_pkg.
module smd_lfo (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  smd_pkg::t_lfo_ctl                     i_ctl,
    input  logic [smd_pkg::PHASE_W-1:0]           i_phase_step,
    input  logic [smd_pkg::DEPTH_W-1:0]           i_depth,
    output logic signed [smd_pkg::OFFSET_W-1:0]   o_offset
);
    import smd_pkg::*;

    localparam int TW  = $clog2(SINE_TABLE_SIZE);
    localparam int PRW = DEPTH_W + SINE_W;
    localparam int EW  = PRW + 1 - Q15_SHIFT;

    logic [PHASE_W-1:0]         r_phase;
    logic [DEPTH_W-1:0]         r_depth;
    logic [PRW-1:0]             r_prod;
    logic                       r_neg;
    logic signed [OFFSET_W-1:0] r_offset;

    logic [1:0]         quad;
    logic [TW-1:0]      idx;
    logic [TW:0]        lut_addr;
    logic [SINE_W-1:0]  s_abs;
    logic [PRW-1:0]     n_prod;
    logic [PRW:0]       est_sum;
    logic [EW-1:0]      est;
    logic [PRW:0]       est_back;
    logic [EW-1:0]      est_fix;
    logic [OFFSET_W-1:0] mag;
    logic [OFFSET_W-1:0] n_offset;

    always_comb begin
        quad     = r_phase[PHASE_W-1 -: 2];
        idx      = r_phase[PHASE_W-3 -: TW];
        lut_addr = quad[0] ? ((TW+1)'(SINE_TABLE_SIZE) - {1'b0, idx}) : {1'b0, idx};
        s_abs    = SINE_LUT[lut_addr];
        n_prod   = PRW'(r_depth) * PRW'(s_abs);
    end

    always_comb begin
        est_sum  = {1'b0, r_prod} + (PRW+1)'(r_prod >> Q15_SHIFT) + (PRW+1)'(2);
        est      = est_sum[PRW -: EW];
        est_back = {est, {Q15_SHIFT{1'b0}}} - (PRW+1)'(est);
        est_fix  = (est_back > {1'b0, r_prod}) ? (est - EW'(1)) : est;
        mag      = OFFSET_W'(est_fix);
        n_offset = r_neg ? (OFFSET_W'(0) - mag) : mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_ctl.advance) begin
            r_phase <= r_phase + i_phase_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_depth <= i_depth;
        end
        if (i_ctl.scale) begin
            r_prod <= n_prod;
            r_neg  <= quad[1];
        end
        if (i_ctl.divide) begin
            r_offset <= $signed(n_offset);
        end
    end

    assign o_offset = r_offset;

endmodule

// ----- hdl/smd_lane.sv -----
// One channel lane: circular sample store, tap read and Q15 dry/wet mixer.
// Depends on smd_pkg.
module smd_lane #(
    parameter int BUF_DEPTH = smd_pkg::BUF_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  smd_pkg::t_lane_ctl           i_ctl,
    input  logic [$clog2(BUF_DEPTH)-1:0] i_wr_addr,
    input  logic [$clog2(BUF_DEPTH)-1:0] i_rd_addr,
    input  smd_pkg::t_sample             i_sample,
    input  logic [smd_pkg::WET_W-1:0]    i_wet,
    output smd_pkg::t_sample             o_mix
);
    import smd_pkg::*;

    localparam int PW = SAMPLE_WIDTH + WET_W + 1;
    localparam int SW = PW + 1;
    localparam int QW = SW - Q15_SHIFT;
    localparam logic signed [QW-1:0] SAT_HI = QW'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [QW-1:0] SAT_LO = QW'(-(1 << (SAMPLE_WIDTH - 1)));
    localparam logic signed [SW-1:0] ROUND  = SW'(1 << (Q15_SHIFT - 1));

    t_sample mem [BUF_DEPTH];

    t_sample               r_dry;
    t_sample               r_rdata;
    logic                  r_hit;
    logic signed [PW-1:0]  r_pd;
    logic signed [PW-1:0]  r_pw;

    logic [WET_W-1:0]      dry_w;
    t_sample               tap;
    logic signed [PW-1:0]  n_pd;
    logic signed [PW-1:0]  n_pw;
    logic signed [SW-1:0]  sum;
    logic signed [QW-1:0]  q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_sample;
            r_dry          <= i_sample;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= mem[i_rd_addr];
            r_hit   <= i_ctl.rd_hit;
        end
        if (i_ctl.mul_en) begin
            r_pd <= n_pd;
            r_pw <= n_pw;
        end
    end

    always_comb begin
        dry_w = WET_ONE - i_wet;
        tap   = r_hit ? r_rdata : '0;
        n_pd  = $signed({1'b0, dry_w}) * r_dry;
        n_pw  = $signed({1'b0, i_wet}) * tap;
        sum   = $signed({r_pd[PW-1], r_pd}) + $signed({r_pw[PW-1], r_pw}) + ROUND;
        q     = sum[SW-1 -: QW];
        if (q > SAT_HI) begin
            o_mix = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (q < SAT_LO) begin
            o_mix = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            o_mix = q[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

// ----- hdl/stereo_modulated_delay_core.sv -----
// Stereo modulated delay core: two channel lanes share one LFO and a merged output register.
// An accepted pair steps through r_stg[0] (LFO scale), r_stg[1] (LFO divide), r_stg[2]
// (tap read), r_stg[3] (mix multiply), r_stg[4] (held while output stalls); one pair is in
// flight, since the next write may overwrite the oldest entry that the current tap reads.
// Reset: synchronous active low; stores read as zero until written (fill count, no sweep).
`include "stereo_modulated_delay_core_defines.svh"

module stereo_modulated_delay_core #(
    parameter int BUF_DEPTH = smd_pkg::BUF_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    smd_stream_if.sink                  i_in,
    smd_stream_if.source                o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [smd_pkg::APB_AW-1:0]  paddr,
    input  logic [smd_pkg::APB_DW-1:0]  pwdata,
    output logic [smd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import smd_pkg::*;

    localparam int AW     = $clog2(BUF_DEPTH);
    localparam int BDW    = $clog2(BUF_DEPTH + 1);
    localparam int CW     = (AW + 2 > BDLY_W + 1) ? AW + 2 : BDLY_W + 1;
    localparam int STAGES = 5;
    localparam logic [CW-1:0] BUF_C = CW'(BUF_DEPTH);

    logic [WET_W-1:0]   r_wet_gain;
    logic [PHASE_W-1:0] r_phase_step;
    logic [BDLY_W-1:0]  r_base_delay;
    logic [DEPTH_W-1:0] r_mod_depth;

    logic [STAGES-1:0]  r_stg;
    logic [AW-1:0]      r_wi;
    logic [BDW-1:0]     r_fill;
    logic [BDW-1:0]     r_bd;
    logic               r_out_vld;
    t_out_beat          r_out;

    logic               acc;
    logic               take;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;
    logic [CW-1:0]      bd_ext;
    logic [CW-1:0]      bd_c;
    logic [CW-1:0]      dep;
    logic [WET_W-1:0]   wet_c;
    logic [AW-1:0]      n_wi;
    logic [STAGES-1:0]  n_stg;
    logic signed [OFFSET_W-1:0] offset;
    logic [CW-1:0]      tap_sum;
    logic [CW-1:0]      tap_wrap;
    logic [AW-1:0]      tap;
    logic               hit;
    t_lfo_ctl           lfo_ctl;
    t_lane_ctl          lane_ctl;
    t_sample            mix_l;
    t_sample            mix_r;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wet_gain   <= WET_W'(16384);
            r_phase_step <= PHASE_W'(134218);
            r_base_delay <= BDLY_W'(300);
            r_mod_depth  <= DEPTH_W'(150);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WET_GAIN:   r_wet_gain   <= pwdata[WET_W-1:0];
                REG_PHASE_STEP: r_phase_step <= pwdata[PHASE_W-1:0];
                REG_BASE_DELAY: r_base_delay <= pwdata[BDLY_W-1:0];
                REG_MOD_DEPTH:  r_mod_depth  <= pwdata[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WET_GAIN:   prdata = APB_DW'(r_wet_gain);
            REG_PHASE_STEP: prdata = APB_DW'(r_phase_step);
            REG_BASE_DELAY: prdata = APB_DW'(r_base_delay);
            REG_MOD_DEPTH:  prdata = APB_DW'(r_mod_depth);
            default:        prdata = '0;
        endcase
    end

    // clamp delay and swing so the tap stays inside written history
    always_comb begin
        bd_ext = CW'(r_base_delay);
        if (bd_ext == '0) begin
            bd_c = CW'(1);
        end else if (bd_ext > BUF_C) begin
            bd_c = BUF_C;
        end else begin
            bd_c = bd_ext;
        end
        dep = CW'(r_mod_depth);
        if (dep > bd_c - CW'(1)) begin
            dep = bd_c - CW'(1);
        end
        if (dep > BUF_C - bd_c) begin
            dep = BUF_C - bd_c;
        end
        wet_c = (r_wet_gain > WET_ONE) ? WET_ONE : r_wet_gain;
    end

    assign i_in.ready = ~|r_stg;
    assign acc        = i_in.valid && i_in.ready;
    assign take       = r_stg[STAGES-1] && (!r_out_vld || o_out.ready);
    assign n_wi       = (r_wi == AW'(BUF_DEPTH - 1)) ? '0 : r_wi + AW'(1);

    always_comb begin
        n_stg    = {r_stg[STAGES-2:0], acc};
        n_stg[STAGES-1] = r_stg[STAGES-2] || (r_stg[STAGES-1] && !take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg     <= '0;
            r_wi      <= '0;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_stg     <= n_stg;
            r_out_vld <= take || (r_out_vld && !o_out.ready);
            if (acc) begin
                r_wi <= n_wi;
                if (r_fill != BDW'(BUF_DEPTH)) begin
                    r_fill <= r_fill + BDW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_bd <= bd_c[BDW-1:0];
        end
        if (take) begin
            r_out.left_out  <= mix_l;
            r_out.right_out <= mix_r;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    always_comb begin
        tap_sum  = CW'(r_wi) + BUF_C - CW'(r_bd) + {{(CW-OFFSET_W){offset[OFFSET_W-1]}}, offset};
        tap_wrap = (tap_sum >= BUF_C) ? (tap_sum - BUF_C) : tap_sum;
        tap      = tap_wrap[AW-1:0];
        hit      = tap_wrap < CW'(r_fill);
    end

    assign lfo_ctl  = '{advance: acc, scale: r_stg[0], divide: r_stg[1]};
    assign lane_ctl = '{wr_en: acc, rd_en: r_stg[2], rd_hit: hit, mul_en: r_stg[3]};

    smd_lfo u_lfo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (lfo_ctl),
        .i_phase_step (r_phase_step),
        .i_depth      (dep[DEPTH_W-1:0]),
        .o_offset     (offset)
    );

    smd_lane #(.BUF_DEPTH(BUF_DEPTH)) u_lane_l (
        .i_clk     (i_clk),
        .i_ctl     (lane_ctl),
        .i_wr_addr (r_wi),
        .i_rd_addr (tap),
        .i_sample  (i_in.data.left_sample),
        .i_wet     (wet_c),
        .o_mix     (mix_l)
    );

    smd_lane #(.BUF_DEPTH(BUF_DEPTH)) u_lane_r (
        .i_clk     (i_clk),
        .i_ctl     (lane_ctl),
        .i_wr_addr (r_wi),
        .i_rd_addr (tap),
        .i_sample  (i_in.data.right_sample),
        .i_wet     (wet_c),
        .o_mix     (mix_r)
    );

    `SMD_ASSERT_IMPL(a_single_item, 1'b1, $onehot0(r_stg))
    `SMD_ASSERT_NEXT(a_accept_enters, acc, r_stg[0] && $onehot(r_stg))
    `SMD_ASSERT_IMPL(a_fill_bound, 1'b1, r_fill <= BDW'(BUF_DEPTH))
    `SMD_ASSERT_IMPL(a_tap_in_range, r_stg[2], tap_wrap < BUF_C)
    `SMD_ASSERT_IMPL(a_hold_when_blocked, r_stg[STAGES-1] && !take, r_out_vld && !o_out.ready)

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for stereo_modulated_delay_core: stream beats in and out with random
// idling, registers written over the APB port, results checked beat by beat against a predictor.
// Depends on smd_pkg, smd_stream_if and the core itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smd_pkg::*;

    localparam int          BUF_LEN       = BUF_DEPTH_DEF;
    localparam int          IDLE_LIMIT    = 1000;
    localparam int          SETTLE_CYCLES = 12;
    localparam logic [63:0] Q30_HALF_PI   = 64'd1686629713;
    localparam logic [63:0] Q30_ONE       = 64'd1073741824;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    smd_stream_if #(.T(t_in_beat))  in_if ();
    smd_stream_if #(.T(t_out_beat)) out_if ();

    stereo_modulated_delay_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    int          quarter_sine [SINE_TABLE_SIZE+1];
    t_sample     left_hist [BUF_LEN];
    t_sample     right_hist [BUF_LEN];
    int          wr_ptr;
    logic [31:0] phase_acc;
    logic [15:0] wet_reg;
    logic [31:0] step_reg;
    logic [8:0]  delay_reg;
    logic [7:0]  depth_reg;
    t_out_beat   pending_mix [$];
    int          errors;
    bit          src_gaps;
    bit          sink_stalls;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void build_quarter_sine();
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] v;
        longint      acc;
        for (int i = 0; i <= SINE_TABLE_SIZE; i++) begin
            x    = (Q30_HALF_PI * 64'(i)) / 64'(SINE_TABLE_SIZE);
            term = x;
            acc  = longint'(x);
            for (int k = 1; k <= 6; k++) begin
                term = (term * x) >> 30;
                term = ((term * x) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            v = (64'(acc) * 64'd32767 + (Q30_ONE >> 1)) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            quarter_sine[i] = int'(v);
        end
    endfunction

    function automatic int lfo_sine(input logic [31:0] ph);
        int idx;
        int v;
        idx = int'((64'(ph[29:0]) * 64'(SINE_TABLE_SIZE)) >> 30);
        if (idx > SINE_TABLE_SIZE) begin
            idx = SINE_TABLE_SIZE;
        end
        v = ph[30] ? quarter_sine[SINE_TABLE_SIZE - idx] : quarter_sine[idx];
        return ph[31] ? -v : v;
    endfunction

    function automatic t_sample q15_mix(input int dry, input int tap, input int wet);
        longint acc;
        longint r;
        acc = longint'(32768 - wet) * longint'(dry) + longint'(wet) * longint'(tap) + 64'sd16384;
        r   = acc >>> 15;
        if (r > 32767) begin
            r = 32767;
        end
        if (r < -32768) begin
            r = -32768;
        end
        return t_sample'(r);
    endfunction

    function automatic t_out_beat vibrato_step(input t_in_beat beat);
        int        wet;
        int        bd;
        int        depth;
        int        s;
        int        mag;
        int        d;
        int        tap;
        t_out_beat r;
        wet   = (wet_reg > 16'd32768) ? 32768 : int'(wet_reg);
        bd    = int'(delay_reg);
        depth = int'(depth_reg);
        if (bd < 1) begin
            bd = 1;
        end
        if (bd > BUF_LEN) begin
            bd = BUF_LEN;
        end
        if (depth > bd - 1) begin
            depth = bd - 1;
        end
        if (depth > BUF_LEN - bd) begin
            depth = BUF_LEN - bd;
        end
        phase_acc = phase_acc + step_reg;
        s   = lfo_sine(phase_acc);
        mag = (depth * (s < 0 ? -s : s)) / 32767;
        d   = (s < 0) ? -mag : mag;
        left_hist[wr_ptr]  = beat.left_sample;
        right_hist[wr_ptr] = beat.right_sample;
        wr_ptr = (wr_ptr + 1) % BUF_LEN;
        tap    = (wr_ptr + BUF_LEN - bd + d) % BUF_LEN;
        r.left_out  = q15_mix(int'(beat.left_sample), int'(left_hist[tap]), wet);
        r.right_out = q15_mix(int'(beat.right_sample), int'(right_hist[tap]), wet);
        return r;
    endfunction

    function automatic t_in_beat random_pair();
        t_in_beat b;
        case ($urandom_range(0, 9))
            0: b = {16'sh7FFF, 16'sh8000};
            1: b = {16'sh8000, 16'sh7FFF};
            default: b = $urandom;
        endcase
        return b;
    endfunction

    task automatic send_pair(input t_in_beat beat);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.data  = beat;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        pending_mix.push_back(vibrato_step(beat));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_if.valid = 1'b0;
        while (pending_mix.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] stored;
        logic [31:0] readback;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        case (idx)
            REG_WET_GAIN:   begin wet_reg   = value[15:0]; stored = {16'd0, value[15:0]}; end
            REG_PHASE_STEP: begin step_reg  = value;       stored = value;                end
            REG_BASE_DELAY: begin delay_reg = value[8:0];  stored = {23'd0, value[8:0]};  end
            default:        begin depth_reg = value[7:0];  stored = {24'd0, value[7:0]};  end
        endcase
        psel   = 1'b1;
        pwrite = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        readback = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback !== stored) begin
            $error("register %s readback: expected %0h, got %0h", idx.name(), stored, readback);
            errors++;
        end
    endtask

    task automatic load_registers(input logic [31:0] wet, input logic [31:0] step,
                                  input logic [31:0] delay, input logic [31:0] depth);
        wait_idle();
        apb_write(REG_WET_GAIN, wet);
        apb_write(REG_PHASE_STEP, step);
        apb_write(REG_BASE_DELAY, delay);
        apb_write(REG_MOD_DEPTH, depth);
    endtask

    task automatic test_reset_settings();
        t_in_beat pairs [8];
        pairs = '{{16'sh0000, 16'sh0000}, {16'sh7FFF, 16'sh8000}, {16'sh8000, 16'sh7FFF},
                  {16'shFFFF, 16'sh0001}, {16'sh7FFF, 16'sh7FFF}, {16'sh8000, 16'sh8000},
                  {16'sh5555, 16'shAAAA}, {16'shAAAA, 16'sh5555}};
        foreach (pairs[i]) begin
            send_pair(pairs[i]);
        end
    endtask

    task automatic test_register_extremes();
        load_registers(32'd0, 32'h4000_0000, 32'd1, 32'd255);
        repeat (3) send_pair(random_pair());
        load_registers(32'd32768, 32'hFFFF_FFFF, 32'd511, 32'd255);
        repeat (3) send_pair(random_pair());
        load_registers(32'd65535, 32'd0, 32'd0, 32'd0);
        repeat (3) send_pair(random_pair());
        load_registers(32'd16384, 32'h0100_0000, 32'd256, 32'd255);
        repeat (3) send_pair(random_pair());
    endtask

    task automatic test_random_sweeps();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        for (int p = 0; p < 4; p++) begin
            load_registers(($urandom_range(0, 3) == 0) ? $urandom_range(32768, 65535)
                                                       : $urandom_range(0, 32768),
                           $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 24),
                           $urandom_range(0, 511), $urandom_range(0, 255));
            for (int n = 0; n < 110; n++) begin
                if (p == 1 && n == 55) begin
                    wait_idle();
                end
                send_pair(random_pair());
            end
        end
    endtask

    task automatic test_steady_stream();
        load_registers($urandom_range(0, 32768), $urandom, $urandom_range(1, 511),
                       $urandom_range(0, 255));
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        repeat (60) send_pair(random_pair());
    endtask

    initial begin
        int stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
                out_if.ready = 1'b0;
                stall_left   = $urandom_range(0, 6);
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    initial begin
        t_out_beat got;
        t_out_beat want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got = out_if.data;
                if (pending_mix.size() == 0) begin
                    $error("output beat with no result pending: %0d %0d",
                           got.left_out, got.right_out);
                    errors++;
                end else begin
                    want = pending_mix.pop_front();
                    if (got.left_out !== want.left_out) begin
                        $error("left_out mismatch: expected %0d, got %0d",
                               want.left_out, got.left_out);
                        errors++;
                    end
                    if (got.right_out !== want.right_out) begin
                        $error("right_out mismatch: expected %0d, got %0d",
                               want.right_out, got.right_out);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
                (psel && penable)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("stereo_modulated_delay_core test failed");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        errors      = 0;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        build_quarter_sine();
        foreach (left_hist[i]) begin
            left_hist[i]  = '0;
            right_hist[i] = '0;
        end
        wr_ptr    = 0;
        phase_acc = '0;
        wet_reg   = 16'd16384;
        step_reg  = 32'd134218;
        delay_reg = 9'd300;
        depth_reg = 8'd150;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_settings();
        test_register_extremes();
        test_random_sweeps();
        test_steady_stream();
        wait_idle();

        if (errors == 0 && pending_mix.size() == 0) begin
            $display("stereo_modulated_delay_core test passed");
        end else begin
            $display("stereo_modulated_delay_core test failed");
        end
        $finish;
    end
endmodule
